// File: hdl/m3i_pkg.sv
package m3i_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ENT_N = 9;        // entries of one matrix
  localparam int EW    = 32;       // entry width
  localparam int PW    = 2 * EW;   // pair product width
  localparam int CW    = PW + 1;   // signed cofactor width
  localparam int CMW   = PW;       // cofactor magnitude width
  localparam int DW    = 97;       // signed determinant width
  localparam int DMW   = DW - 1;   // determinant magnitude width
  localparam int QW    = EW;       // quotient bits kept
  localparam int FST   = 6;        // front-end register stages

  localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

  typedef logic signed [EW-1:0] ent_t;
  typedef logic [3:0] idx_t;

  // cofactor k = m[P]*m[Q] - m[S]*m[T], adjugate order, row-major
  localparam idx_t COF_P [ENT_N] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_Q [ENT_N] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_S [ENT_N] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_T [ENT_N] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  // cofactors of row 0 used for the determinant expansion
  localparam idx_t DET_C [3] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic [CMW-1:0] cmag;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } div_res_t;

endpackage

// File: hdl/m3i_front.sv
module m3i_front import m3i_pkg::*; (
  input  logic           clk,
  input  logic           adv,
  input  ent_t           m [ENT_N],
  output lane_t          lane [ENT_N],
  output logic [DMW-1:0] dmag,
  output logic           sing
);

  logic signed [PW-1:0] pa [ENT_N];
  logic signed [PW-1:0] pb [ENT_N];
  ent_t                 r0_1 [3];
  ent_t                 r0_2 [3];
  logic signed [CW-1:0] cof2 [ENT_N];
  logic signed [CW-1:0] cof3 [ENT_N];
  logic signed [CW-1:0] cof4 [ENT_N];
  logic signed [CW-1:0] cof5 [ENT_N];
  logic signed [CW-1:0] ph [3];
  logic signed [CW-1:0] pl [3];
  logic signed [DW-1:0] t4 [3];
  logic signed [DW-1:0] det5;
  logic        [DW-1:0] dneg;
  logic        [CW-1:0] cneg [ENT_N];

  // stage 1: pair products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ENT_N; k++) begin
        pa[k] <= m[COF_P[k]] * m[COF_Q[k]];
        pb[k] <= m[COF_S[k]] * m[COF_T[k]];
      end
      for (int j = 0; j < 3; j++) r0_1[j] <= m[j];
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < ENT_N; k++) cof2[k] <= CW'(pa[k]) - CW'(pb[k]);
      r0_2 <= r0_1;
    end
  end

  // stage 3: split row-0 products into high and low halves
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        ph[j] <= r0_2[j] * $signed(cof2[DET_C[j]][CW-1:EW]);
        pl[j] <= r0_2[j] * $signed({1'b0, cof2[DET_C[j]][EW-1:0]});
      end
      cof3 <= cof2;
    end
  end

  // stage 4: recombine halves
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) t4[j] <= $signed({ph[j], {EW{1'b0}}} + DW'(pl[j]));
      cof4 <= cof3;
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk) begin
    if (adv) begin
      det5 <= t4[0] + t4[1] + t4[2];
      cof5 <= cof4;
    end
  end

  // stage 6: sign and magnitude
  always_comb begin
    dneg = -det5;
    for (int k = 0; k < ENT_N; k++) cneg[k] = -cof5[k];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag <= det5[DW-1] ? dneg[DMW-1:0] : det5[DMW-1:0];
      sing <= (det5 == '0);
      for (int k = 0; k < ENT_N; k++) begin
        lane[k].neg  <= cof5[k][CW-1] ^ det5[DW-1];
        lane[k].cmag <= cof5[k][CW-1] ? cneg[k][CMW-1:0] : cof5[k][CMW-1:0];
      end
    end
  end

endmodule

// File: hdl/m3i_div.sv
module m3i_div import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           adv,
  input  lane_t          lin,
  input  logic [DMW-1:0] den,
  output div_res_t       res
);

  localparam int NW = CMW + 2 * FRAC_BITS;
  localparam int RW = (NW > DMW + QW) ? NW : DMW + QW;

  logic [RW-1:0] rem [QW];
  logic [RW-1:0] dv  [QW];
  logic [QW-1:0] q   [QW+1];
  logic          ovf [QW+1];
  logic          neg [QW+1];
  logic [RW-1:0] num;
  logic [RW-1:0] den_w;

  assign num   = {{(RW-CMW){1'b0}}, lin.cmag} << (2 * FRAC_BITS);
  assign den_w = {{(RW-DMW){1'b0}}, den};

  // quotient of 2^QW or more always saturates
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= num;
      dv[0]  <= den_w;
      q[0]   <= '0;
      ovf[0] <= (num >= (den_w << QW));
      neg[0] <= lin.neg;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int SH = QW - k;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = dv[k-1] << SH;
    assign ge  = (rem[k-1] >= dsh);
    always_ff @(posedge clk) begin
      if (adv) begin
        q[k]   <= {q[k-1][QW-2:0], ge};
        ovf[k] <= ovf[k-1];
        neg[k] <= neg[k-1];
      end
    end
    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k] <= ge ? rem[k-1] - dsh : rem[k-1];
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign res = '{q: q[QW], ovf: ovf[QW], neg: neg[QW]};

endmodule

// File: hdl/matrix3x3_inverse.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_stall  | a00 .. a22, signed fixed point
// output  | out_valid / out_stall| r00 .. r22, singular
//
// One matrix per cycle while the skid entry is empty; the path is six front-end stages (products,
// cofactors, determinant), 33 divider stages (one quotient bit per stage in
// each of nine lanes), one output register.
// Reset clears the valid bits and the output and skid flags only.
// The pipeline holds only while the skid entry is full; the output register
// and skid entry let one transaction wait at the output without stalling input.
module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [EW-1:0] a00,
  input  logic signed [EW-1:0] a01,
  input  logic signed [EW-1:0] a02,
  input  logic signed [EW-1:0] a10,
  input  logic signed [EW-1:0] a11,
  input  logic signed [EW-1:0] a12,
  input  logic signed [EW-1:0] a20,
  input  logic signed [EW-1:0] a21,
  input  logic signed [EW-1:0] a22,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [EW-1:0] r00,
  output logic signed [EW-1:0] r01,
  output logic signed [EW-1:0] r02,
  output logic signed [EW-1:0] r10,
  output logic signed [EW-1:0] r11,
  output logic signed [EW-1:0] r12,
  output logic signed [EW-1:0] r20,
  output logic signed [EW-1:0] r21,
  output logic signed [EW-1:0] r22,
  output logic        singular
);

  localparam int NST = FST + QW + 1;

  ent_t           m [ENT_N];
  lane_t          lane [ENT_N];
  logic [DMW-1:0] dmag;
  logic           f_sing;
  div_res_t       dres [ENT_N];
  logic           sd [QW+1];
  logic [NST-1:0] v;
  logic           adv;
  logic           inc;
  ent_t           res_val [ENT_N];
  logic           ov;
  logic           sv;
  ent_t           o_val [ENT_N];
  ent_t           s_val [ENT_N];
  logic           o_sing;
  logic           s_sing;

  function automatic ent_t sat_q(input div_res_t d);
    ent_t r;
    if (!d.neg) begin
      r = (d.ovf || d.q[QW-1]) ? SAT_MAX : d.q;
    end else begin
      r = (d.ovf || (d.q > SAT_MIN)) ? SAT_MIN : -d.q;
    end
    return r;
  endfunction

  assign m = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  // advance the whole pipeline unless the skid entry is occupied
  assign adv      = !sv;
  assign in_stall = sv;
  assign inc      = adv && v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  m3i_front u_front (
    .clk  (clk),
    .adv  (adv),
    .m    (m),
    .lane (lane),
    .dmag (dmag),
    .sing (f_sing)
  );

  for (genvar k = 0; k < ENT_N; k++) begin : g_lane
    m3i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .adv (adv),
      .lin (lane[k]),
      .den (dmag),
      .res (dres[k])
    );
  end

  // carry the singular flag alongside the divider lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= f_sing;
      for (int k = 1; k <= QW; k++) sd[k] <= sd[k-1];
    end
  end

  // saturate, and drop everything to zero for a singular matrix
  always_comb begin
    for (int k = 0; k < ENT_N; k++) res_val[k] = sd[QW] ? '0 : sat_q(dres[k]);
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || !out_stall) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= inc;
      end
    end else if (inc) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || !out_stall) begin
      if (sv) begin
        o_val  <= s_val;
        o_sing <= s_sing;
      end else begin
        o_val  <= res_val;
        o_sing <= sd[QW];
      end
    end
    if (ov && out_stall && !sv) begin
      s_val  <= res_val;
      s_sing <= sd[QW];
    end
  end

  assign out_valid = ov;
  assign r00 = o_val[0];
  assign r01 = o_val[1];
  assign r02 = o_val[2];
  assign r10 = o_val[3];
  assign r11 = o_val[4];
  assign r12 = o_val[5];
  assign r20 = o_val[6];
  assign r21 = o_val[7];
  assign r22 = o_val[8];
  assign singular = o_sing;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (sv && !out_stall) |=> !sv)
    else $error("skid entry not drained after output taken");

  a_pipe_lands: assert property (@(posedge clk) disable iff (rst)
    (v[NST-1] && !sv) |=> ov)
    else $error("transaction leaving pipeline was lost");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && o_sing) |-> (o_val[0] == '0 && o_val[1] == '0 && o_val[2] == '0 &&
                        o_val[3] == '0 && o_val[4] == '0 && o_val[5] == '0 &&
                        o_val[6] == '0 && o_val[7] == '0 && o_val[8] == '0))
    else $error("singular result with nonzero entries");

endmodule
